// ----- src/tgrc_pkg.sv -----
`timescale 1ns / 1ps

package tgrc_pkg;

    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
    localparam logic [7:0] BYTE_G         = 8'h47;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_SEMICOLON = 8'h3B;
    localparam logic [7:0] BYTE_O         = 8'h4F;
    localparam logic [7:0] BYTE_K         = 8'h4B;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
    localparam logic [7:0] BYTE_QUESTION  = 8'h3F;
    localparam logic [7:0] BYTE_FOUR      = 8'h34;
    localparam logic [7:0] BYTE_C         = 8'h63;

    localparam logic [1:0] PREFIX_NONE     = 2'd0;
    localparam logic [1:0] PREFIX_ESC      = 2'd1;
    localparam logic [1:0] PREFIX_SECOND   = 2'd2;
    localparam logic [1:0] PREFIX_COMPLETE = 2'd3;

    localparam logic [1:0] OK_NONE  = 2'd0;
    localparam logic [1:0] OK_SEMI  = 2'd1;
    localparam logic [1:0] OK_O     = 2'd2;

    localparam logic [1:0] TOKEN_EMPTY = 2'd0;
    localparam logic [1:0] TOKEN_FOUR  = 2'd1;
    localparam logic [1:0] TOKEN_OTHER = 2'd2;

    localparam logic [1:0] BACKEND_NONE  = 2'd0;
    localparam logic [1:0] BACKEND_KITTY = 2'd1;
    localparam logic [1:0] BACKEND_SIXEL = 2'd2;

    typedef enum logic [2:0] {
        KITTY_SEARCH = 3'b001,
        KITTY_FRAME  = 3'b010,
        KITTY_CLOSED = 3'b100
    } kitty_phase_t;

    typedef enum logic [2:0] {
        DA_SEARCH = 3'b001,
        DA_PARAMS = 3'b010,
        DA_DONE   = 3'b100
    } da_phase_t;

    // ESC-led three byte prefix matcher; no other ESC in the pattern
    function automatic logic [1:0] prefix_advance(input logic [1:0] prog,
                                                  input logic [7:0] b,
                                                  input logic [7:0] second,
                                                  input logic [7:0] third);
        logic [1:0] res;
        if (prog == PREFIX_ESC && b == second) begin
            res = PREFIX_SECOND;
        end else if (prog == PREFIX_SECOND && b == third) begin
            res = PREFIX_COMPLETE;
        end else if (b == BYTE_ESC) begin
            res = PREFIX_ESC;
        end else begin
            res = PREFIX_NONE;
        end
        return res;
    endfunction

endpackage

// ----- src/terminal_graphics_reply_classifier_unit.sv -----
`timescale 1ns / 1ps

// Classifies a terminal reply fed one byte per beat and returns one backend
// code (none, kitty, sixel) for the byte marked final, in the result register
// or, while the sink stalls, the spare one; other bytes give no result.
// One byte is taken every cycle while s_ready is high. A spare register behind
// the result register lets the next reply run on while a result waits to be
// taken. Input stalls only when both hold results. s_ready comes straight from
// a register. Kitty wins over sixel; all state clears after the final byte.
module terminal_graphics_reply_classifier_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_reply_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_backend
);

    tgrc_pkg::kitty_phase_t kitty_phase_reg, kitty_phase_next;
    logic [1:0] kitty_prog_reg, kitty_prog_next;
    logic [1:0] ok_prog_reg, ok_prog_next;
    logic       frame_esc_reg, frame_esc_next;
    logic       kitty_found_reg, kitty_found_next;

    tgrc_pkg::da_phase_t da_phase_reg, da_phase_next;
    logic [1:0] da_prog_reg, da_prog_next;
    logic [1:0] token_reg, token_next;
    logic       sixel_found_reg, sixel_found_next;

    logic       m_valid_reg;
    logic [1:0] m_backend_reg, backend_next;
    logic       spare_valid_reg;
    logic [1:0] spare_backend_reg;
    logic       accept;
    logic       load;
    logic [1:0] kitty_adv, da_adv;

    assign s_ready   = !spare_valid_reg;
    assign accept    = s_valid && s_ready;
    assign load      = accept && s_final_byte;
    assign m_valid   = m_valid_reg;
    assign m_backend = m_backend_reg;

    assign kitty_adv = tgrc_pkg::prefix_advance(kitty_prog_reg, s_reply_byte,
                                                tgrc_pkg::BYTE_UNDERSCORE,
                                                tgrc_pkg::BYTE_G);
    assign da_adv    = tgrc_pkg::prefix_advance(da_prog_reg, s_reply_byte,
                                                tgrc_pkg::BYTE_LBRACKET,
                                                tgrc_pkg::BYTE_QUESTION);

    always_comb begin
        kitty_phase_next = kitty_phase_reg;
        kitty_prog_next  = kitty_prog_reg;
        ok_prog_next     = ok_prog_reg;
        frame_esc_next   = frame_esc_reg;
        kitty_found_next = kitty_found_reg;
        unique case (kitty_phase_reg)
            tgrc_pkg::KITTY_SEARCH: begin
                if (kitty_adv == tgrc_pkg::PREFIX_COMPLETE) begin
                    kitty_phase_next = tgrc_pkg::KITTY_FRAME;
                    kitty_prog_next  = tgrc_pkg::PREFIX_NONE;
                    ok_prog_next     = tgrc_pkg::OK_NONE;
                    frame_esc_next   = 1'b0;
                end else begin
                    kitty_prog_next = kitty_adv;
                end
            end
            tgrc_pkg::KITTY_FRAME: begin
                if (frame_esc_reg && s_reply_byte == tgrc_pkg::BYTE_BACKSLASH) begin
                    kitty_phase_next = tgrc_pkg::KITTY_CLOSED;
                    frame_esc_next   = 1'b0;
                    ok_prog_next     = tgrc_pkg::OK_NONE;
                end else begin
                    frame_esc_next = (s_reply_byte == tgrc_pkg::BYTE_ESC);
                    if (ok_prog_reg == tgrc_pkg::OK_SEMI
                            && s_reply_byte == tgrc_pkg::BYTE_O) begin
                        ok_prog_next = tgrc_pkg::OK_O;
                    end else if (ok_prog_reg == tgrc_pkg::OK_O
                            && s_reply_byte == tgrc_pkg::BYTE_K) begin
                        kitty_found_next = 1'b1;
                        ok_prog_next     = tgrc_pkg::OK_NONE;
                    end else if (s_reply_byte == tgrc_pkg::BYTE_SEMICOLON) begin
                        ok_prog_next = tgrc_pkg::OK_SEMI;
                    end else begin
                        ok_prog_next = tgrc_pkg::OK_NONE;
                    end
                end
            end
            tgrc_pkg::KITTY_CLOSED: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        da_phase_next    = da_phase_reg;
        da_prog_next     = da_prog_reg;
        token_next       = token_reg;
        sixel_found_next = sixel_found_reg;
        unique case (da_phase_reg)
            tgrc_pkg::DA_SEARCH: begin
                if (da_adv == tgrc_pkg::PREFIX_COMPLETE) begin
                    da_phase_next = tgrc_pkg::DA_PARAMS;
                    da_prog_next  = tgrc_pkg::PREFIX_NONE;
                    token_next    = tgrc_pkg::TOKEN_EMPTY;
                end else begin
                    da_prog_next = da_adv;
                end
            end
            tgrc_pkg::DA_PARAMS: begin
                if (s_reply_byte == tgrc_pkg::BYTE_C
                        || s_reply_byte == tgrc_pkg::BYTE_SEMICOLON) begin
                    if (token_reg == tgrc_pkg::TOKEN_FOUR) begin
                        sixel_found_next = 1'b1;
                    end
                    token_next = tgrc_pkg::TOKEN_EMPTY;
                    if (s_reply_byte == tgrc_pkg::BYTE_C) begin
                        da_phase_next = tgrc_pkg::DA_DONE;
                    end
                end else if (s_reply_byte == tgrc_pkg::BYTE_FOUR) begin
                    token_next = (token_reg == tgrc_pkg::TOKEN_EMPTY)
                               ? tgrc_pkg::TOKEN_FOUR : tgrc_pkg::TOKEN_OTHER;
                end else begin
                    token_next = tgrc_pkg::TOKEN_OTHER;
                end
            end
            tgrc_pkg::DA_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (kitty_found_next) begin
            backend_next = tgrc_pkg::BACKEND_KITTY;
        end else if (sixel_found_next || (da_phase_next == tgrc_pkg::DA_PARAMS
                && token_next == tgrc_pkg::TOKEN_FOUR)) begin
            backend_next = tgrc_pkg::BACKEND_SIXEL;
        end else begin
            backend_next = tgrc_pkg::BACKEND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_final_byte)) begin
            kitty_phase_reg <= tgrc_pkg::KITTY_SEARCH;
            kitty_prog_reg  <= tgrc_pkg::PREFIX_NONE;
            ok_prog_reg     <= tgrc_pkg::OK_NONE;
            frame_esc_reg   <= 1'b0;
            kitty_found_reg <= 1'b0;
            da_phase_reg    <= tgrc_pkg::DA_SEARCH;
            da_prog_reg     <= tgrc_pkg::PREFIX_NONE;
            token_reg       <= tgrc_pkg::TOKEN_EMPTY;
            sixel_found_reg <= 1'b0;
        end else if (accept) begin
            kitty_phase_reg <= kitty_phase_next;
            kitty_prog_reg  <= kitty_prog_next;
            ok_prog_reg     <= ok_prog_next;
            frame_esc_reg   <= frame_esc_next;
            kitty_found_reg <= kitty_found_next;
            da_phase_reg    <= da_phase_next;
            da_prog_reg     <= da_prog_next;
            token_reg       <= token_next;
            sixel_found_reg <= sixel_found_next;
        end
    end

    // spare holds a second result while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (load) begin
                spare_valid_reg <= 1'b1;
            end
        end else if (spare_valid_reg) begin
            m_valid_reg     <= 1'b1;
            spare_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_ready) begin
            if (load) begin
                spare_backend_reg <= backend_next;
            end
        end else if (spare_valid_reg) begin
            m_backend_reg <= spare_backend_reg;
        end else if (load) begin
            m_backend_reg <= backend_next;
        end
    end

endmodule
